// File: src/wrct_pkg.sv
package wrct_pkg;

    localparam int unsigned HOUR_W     = 5;
    localparam int unsigned MINUTE_W   = 6;
    localparam int unsigned CYCLE_W    = 7;
    localparam int unsigned TOTAL_H_W  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 6;

    localparam int unsigned TICK_DIVIDE_DEF = 4;

    localparam logic [MINUTE_W-1:0] MINUTES_LAST = MINUTE_W'(59);
    localparam logic [CYCLE_W-1:0]  CYCLE_MAX    = CYCLE_W'(127);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_MINUTE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_END_HOUR     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_END_MINUTE   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MINUTES  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_REST_MINUTES = CFG_IDX_W'(5);

    // reset values of the configuration registers
    localparam logic [HOUR_W-1:0]   RST_START_HOUR   = HOUR_W'(8);
    localparam logic [MINUTE_W-1:0] RST_START_MINUTE = MINUTE_W'(0);
    localparam logic [HOUR_W-1:0]   RST_END_HOUR     = HOUR_W'(20);
    localparam logic [MINUTE_W-1:0] RST_END_MINUTE   = MINUTE_W'(0);
    localparam logic [MINUTE_W-1:0] RST_RUN_MINUTES  = MINUTE_W'(2);
    localparam logic [MINUTE_W-1:0] RST_REST_MINUTES = MINUTE_W'(8);
    localparam logic [MINUTE_W-1:0] RST_LAST_MINUTE  = MINUTE_W'(63);

    typedef struct packed {
        logic [HOUR_W-1:0]   now_hour;
        logic [MINUTE_W-1:0] now_minute;
        logic                enabled;
    } t_in;

    typedef struct packed {
        logic                 motor_on;
        logic                 in_window;
        logic                 evaluated;
        logic [TOTAL_H_W-1:0] total_hours;
        logic [MINUTE_W-1:0]  total_minutes;
        logic                 hour_rolled;
    } t_out;

endpackage

// File: src/windowed_run_rest_cycle_timer.sv
// channel  | direction | handshake                     | payload
// ---------+-----------+-------------------------------+---------------------------
// in       | input     | i_in_valid / o_in_stall       | i_in_data  (t_in)
// out      | output    | o_out_valid / i_out_stall     | o_out_data (t_out)
// cfg      | input     | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// one transaction per cycle while o_in_stall is low; each result is registered
// in the result register behind the tick logic, via the skid entry on a stall
// a two-entry output buffer (result register plus skid entry) lets input take
// one more transaction while the output is stalled; o_in_stall is registered
// synchronous active-low reset; configuration returns to its defaults
// configuration writes are always taken (o_cfg_ready tied high)
module windowed_run_rest_cycle_timer
    import wrct_pkg::*;
#(
    parameter int unsigned TICK_DIVIDE = TICK_DIVIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // prescaler width, at least one bit even when every tick acts
    localparam int unsigned PRE_W = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;
    localparam logic [PRE_W:0] PRE_LIMIT = (PRE_W + 1)'(TICK_DIVIDE);

    // configuration registers
    logic [HOUR_W-1:0]   r_start_hour;
    logic [MINUTE_W-1:0] r_start_minute;
    logic [HOUR_W-1:0]   r_end_hour;
    logic [MINUTE_W-1:0] r_end_minute;
    logic [MINUTE_W-1:0] r_run_minutes;
    logic [MINUTE_W-1:0] r_rest_minutes;

    // tick state
    logic [PRE_W-1:0]     r_prescale, n_prescale;
    logic [CYCLE_W-1:0]   r_cycle, n_cycle;
    logic [MINUTE_W-1:0]  r_last_minute, n_last_minute;
    logic                 r_seen_valid, n_seen_valid;
    logic [TOTAL_H_W-1:0] r_hours, n_hours;
    logic [MINUTE_W-1:0]  r_minutes, n_minutes;
    logic                 r_motor, n_motor;
    logic                 r_last_en, n_last_en;

    logic                      in_accept;
    logic [PRE_W:0]            pre_inc;
    logic                      acted;
    logic                      rolled;
    logic                      in_win;
    logic [HOUR_W+MINUTE_W-1:0] now_time, start_time, end_time;
    logic [CYCLE_W-1:0]        run_ext;
    logic [CYCLE_W-1:0]        period;
    t_out                      result;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;

    // configuration writes; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_hour   <= RST_START_HOUR;
            r_start_minute <= RST_START_MINUTE;
            r_end_hour     <= RST_END_HOUR;
            r_end_minute   <= RST_END_MINUTE;
            r_run_minutes  <= RST_RUN_MINUTES;
            r_rest_minutes <= RST_REST_MINUTES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_HOUR:   r_start_hour   <= i_cfg_data[HOUR_W-1:0];
                CFG_START_MINUTE: r_start_minute <= i_cfg_data[MINUTE_W-1:0];
                CFG_END_HOUR:     r_end_hour     <= i_cfg_data[HOUR_W-1:0];
                CFG_END_MINUTE:   r_end_minute   <= i_cfg_data[MINUTE_W-1:0];
                CFG_RUN_MINUTES:  r_run_minutes  <= i_cfg_data[MINUTE_W-1:0];
                CFG_REST_MINUTES: r_rest_minutes <= i_cfg_data[MINUTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // window check on packed {hour, minute}; stop before start wraps midnight
    assign now_time   = {i_in_data.now_hour, i_in_data.now_minute};
    assign start_time = {r_start_hour, r_start_minute};
    assign end_time   = {r_end_hour, r_end_minute};
    assign in_win     = (start_time <= end_time)
                      ? (now_time >= start_time && now_time <= end_time)
                      : (now_time >= start_time || now_time <= end_time);

    assign run_ext = {1'b0, r_run_minutes};
    assign period  = CYCLE_W'(r_run_minutes) + CYCLE_W'(r_rest_minutes);
    assign pre_inc = {1'b0, r_prescale} + (PRE_W + 1)'(1);
    assign acted   = (pre_inc >= PRE_LIMIT);

    always_comb begin
        n_prescale    = r_prescale;
        n_cycle       = r_cycle;
        n_last_minute = r_last_minute;
        n_seen_valid  = r_seen_valid;
        n_hours       = r_hours;
        n_minutes     = r_minutes;
        n_motor       = r_motor;
        n_last_en     = r_last_en;
        rolled        = 1'b0;

        // any enable edge restarts the cycle, falling edge stops the motor
        if (i_in_data.enabled != r_last_en) begin
            n_last_en = i_in_data.enabled;
            n_cycle   = '0;
            if (!i_in_data.enabled) begin
                n_motor = 1'b0;
            end
        end

        n_prescale = acted ? '0 : pre_inc[PRE_W-1:0];

        if (acted) begin
            if (!i_in_data.enabled) begin
                n_motor = 1'b0;
            end else if (in_win) begin
                if (!r_seen_valid) begin
                    // first in-window tick only records the minute
                    n_last_minute = i_in_data.now_minute;
                    n_seen_valid  = 1'b1;
                end else if (r_last_minute != i_in_data.now_minute) begin
                    n_last_minute = i_in_data.now_minute;
                    if (n_cycle != CYCLE_MAX) begin
                        n_cycle = n_cycle + CYCLE_W'(1);
                    end
                    // minute spent in run phase adds to the total
                    if (n_cycle < run_ext) begin
                        if (r_minutes < MINUTES_LAST) begin
                            n_minutes = r_minutes + MINUTE_W'(1);
                        end else begin
                            n_minutes = '0;
                            n_hours   = r_hours + TOTAL_H_W'(1);
                            rolled    = 1'b1;
                        end
                    end
                end
                if (n_cycle < run_ext) begin
                    n_motor = 1'b1;
                end else if (n_cycle < period) begin
                    n_motor = 1'b0;
                end else begin
                    n_cycle = '0;
                    n_motor = 1'b1;
                end
            end else begin
                n_motor = 1'b0;
            end
        end

        result.motor_on      = n_motor;
        result.in_window     = in_win;
        result.evaluated     = acted;
        result.total_hours   = n_hours;
        result.total_minutes = n_minutes;
        result.hour_rolled   = rolled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale    <= '0;
            r_cycle       <= '0;
            r_last_minute <= RST_LAST_MINUTE;
            r_seen_valid  <= 1'b0;
            r_hours       <= '0;
            r_minutes     <= '0;
            r_motor       <= 1'b0;
            r_last_en     <= 1'b1;
        end else if (in_accept) begin
            r_prescale    <= n_prescale;
            r_cycle       <= n_cycle;
            r_last_minute <= n_last_minute;
            r_seen_valid  <= n_seen_valid;
            r_hours       <= n_hours;
            r_minutes     <= n_minutes;
            r_motor       <= n_motor;
            r_last_en     <= n_last_en;
        end
    end

    // result register with skid entry
    wrct_skid #(
        .WIDTH ($bits(t_out))
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (result),
        .o_stall (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    // an hour rollover always leaves the minute total at zero
    a_roll_clears_minutes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hour_rolled) |-> (o_out_data.total_minutes == '0))
        else $error("hour rolled with nonzero minute total");

    // prescaler stays below its divide ratio
    a_prescale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_prescale} < PRE_LIMIT))
        else $error("prescaler out of range");

    // a disabled transaction always leaves the motor off
    a_disabled_motor_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_in_data.enabled) |=> !r_motor)
        else $error("motor on after disabled transaction");

    // the minute record, once valid, stays valid until reset
    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_valid |=> r_seen_valid)
        else $error("last-minute record lost its valid bit");

endmodule

// File: src/wrct_skid.sv
module wrct_skid #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_stall,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_stall
);

    logic             r_main_valid;
    logic [WIDTH-1:0] r_main;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid;
    logic             take_in;
    logic             main_free;

    assign o_stall   = r_skid_valid;
    assign take_in   = i_valid && !r_skid_valid;
    assign main_free = !r_main_valid || !i_stall;
    assign o_valid   = r_main_valid;
    assign o_data    = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            r_main_valid <= r_skid_valid || take_in;
            r_skid_valid <= 1'b0;
        end else if (take_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (take_in) begin
            r_skid <= i_data;
        end
    end

    // skid entry only ever backs up a full main entry
    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry valid with main entry empty");

    // a held result with a new transaction arriving fills the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && i_stall && take_in) |=> r_skid_valid)
        else $error("transaction dropped while output stalled");

    // the skid entry drains into main as soon as the output moves
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_main_valid && !r_skid_valid))
        else $error("skid entry not drained");

endmodule

// File: test/tb_windowed_run_rest_cycle_timer.sv
module tb_windowed_run_rest_cycle_timer;
    timeunit 1ns;
    timeprecision 1ps;

    import wrct_pkg::*;

    localparam time CLK_PERIOD     = 8ns;
    localparam int  RESET_CYCLES   = 12;
    localparam int  SETTLE_CYCLES  = 8;       // result register plus skid entry, with margin
    localparam int  HOLD_CYCLES    = 80;      // long receiver hold-off
    localparam int  CYCLE_LIMIT    = 200000;
    localparam int  REPORT_LIMIT   = 40;      // keep the log short on a broken build

    // indexes past the register list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_REST_MINUTES + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  o_cfg_ready;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    windowed_run_rest_cycle_timer #(
        .TICK_DIVIDE (TICK_DIVIDE_DEF)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // timer predictor: own copy of the window registers and counters
    // ------------------------------------------------------------------
    logic [HOUR_W-1:0]    win_start_hour, win_stop_hour;
    logic [MINUTE_W-1:0]  win_start_min, win_stop_min;
    logic [MINUTE_W-1:0]  run_len, rest_len;

    int unsigned          prescale_cnt;
    logic [CYCLE_W-1:0]   cycle_pos;
    logic [MINUTE_W-1:0]  seen_minute;
    logic                 seen_valid;
    logic [TOTAL_H_W-1:0] run_hr_total;
    logic [MINUTE_W-1:0]  run_min_total;
    logic                 motor_running;
    logic                 prev_enabled;

    function automatic void timer_reset();
        win_start_hour = RST_START_HOUR;
        win_start_min  = RST_START_MINUTE;
        win_stop_hour  = RST_END_HOUR;
        win_stop_min   = RST_END_MINUTE;
        run_len        = RST_RUN_MINUTES;
        rest_len       = RST_REST_MINUTES;
        prescale_cnt   = 0;
        cycle_pos      = '0;
        seen_minute    = RST_LAST_MINUTE;
        seen_valid     = 1'b0;
        run_hr_total   = '0;
        run_min_total  = '0;
        motor_running  = 1'b0;
        prev_enabled   = 1'b1;
    endfunction

    function automatic void timer_set_reg(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_START_HOUR:   win_start_hour = val[HOUR_W-1:0];
            CFG_START_MINUTE: win_start_min  = val[MINUTE_W-1:0];
            CFG_END_HOUR:     win_stop_hour  = val[HOUR_W-1:0];
            CFG_END_MINUTE:   win_stop_min   = val[MINUTE_W-1:0];
            CFG_RUN_MINUTES:  run_len        = val[MINUTE_W-1:0];
            CFG_REST_MINUTES: rest_len       = val[MINUTE_W-1:0];
            default: ;
        endcase
    endfunction

    // one update tick: returns the result the block must give for it
    function automatic t_out advance_timer(t_in item);
        t_out res;
        logic [HOUR_W+MINUTE_W-1:0] now_key, start_key, stop_key;
        logic in_win, acted, rolled;
        now_key   = {item.now_hour, item.now_minute};
        start_key = {win_start_hour, win_start_min};
        stop_key  = {win_stop_hour, win_stop_min};
        // window wraps past midnight when stop sorts before start
        if (start_key <= stop_key) begin
            in_win = (now_key >= start_key) && (now_key <= stop_key);
        end else begin
            in_win = (now_key >= start_key) || (now_key <= stop_key);
        end
        acted  = 1'b0;
        rolled = 1'b0;

        // any enable change restarts the cycle, switching off stops the motor
        if (item.enabled != prev_enabled) begin
            prev_enabled = item.enabled;
            cycle_pos    = '0;
            if (!item.enabled) begin
                motor_running = 1'b0;
            end
        end

        if (prescale_cnt + 1 < TICK_DIVIDE_DEF) begin
            prescale_cnt++;
        end else begin
            prescale_cnt = 0;
            acted        = 1'b1;
        end

        if (acted) begin
            if (!item.enabled) begin
                motor_running = 1'b0;
            end else if (in_win) begin
                if (!seen_valid) begin
                    // first in-window tick after reset only records the minute
                    seen_minute = item.now_minute;
                    seen_valid  = 1'b1;
                end else if (seen_minute != item.now_minute) begin
                    seen_minute = item.now_minute;
                    if (cycle_pos < CYCLE_MAX) begin
                        cycle_pos++;
                    end
                    if (cycle_pos < run_len) begin
                        if (run_min_total < MINUTES_LAST) begin
                            run_min_total++;
                        end else begin
                            run_min_total = '0;
                            run_hr_total++;
                            rolled = 1'b1;
                        end
                    end
                end
                if (cycle_pos < run_len) begin
                    motor_running = 1'b1;
                end else if (int'(cycle_pos) < int'(run_len) + int'(rest_len)) begin
                    motor_running = 1'b0;
                end else begin
                    cycle_pos     = '0;
                    motor_running = 1'b1;
                end
            end else begin
                motor_running = 1'b0;
            end
        end

        res.motor_on      = motor_running;
        res.in_window     = in_win;
        res.evaluated     = acted;
        res.total_hours   = run_hr_total;
        res.total_minutes = run_min_total;
        res.hour_rolled   = rolled;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // queues shared between stimulus, driver and monitor
    // ------------------------------------------------------------------
    t_in  tick_pending[$];      // ticks waiting to be sent; [0] is on the bus
    t_out result_expected[$];   // predicted results, oldest first

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned evals_seen     = 0;
    int unsigned running_evals  = 0;
    int unsigned rolls_seen     = 0;
    int unsigned holds_done     = 0;
    int unsigned cycle_count    = 0;

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("error: result %0d %s got %0h want %0h", results_seen, what, got, want);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transactions with random gaps between them
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // transaction taken at this edge: predict its result now
            if (i_in_valid && !o_in_stall) begin
                result_expected.push_back(advance_timer(tick_pending.pop_front()));
            end

            if (i_in_valid && o_in_stall) begin
                // stalled: payload and valid hold
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (tick_pending.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= tick_pending[0];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // new burst; some long ones with no gap at all
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(60, 200);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall: random modes plus occasional long hold-offs
    // ------------------------------------------------------------------
    t_stall_mode stall_mode = STALL_NONE;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    logic        stall_nxt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                stall_nxt = 1'b1;
            end else if ((holds_done == 0 && tick_pending.size() > 100) ||
                         (holds_done < 4 && tick_pending.size() > 40 &&
                          $urandom_range(0, 299) == 0)) begin
                // sender keeps offering while the block fills and stalls its input
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                stall_nxt = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left  = $urandom_range(16, 128);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    STALL_NONE:   stall_nxt = 1'b0;
                    STALL_LIGHT:  stall_nxt = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  stall_nxt = ($urandom_range(0, 3) != 0);
                    default:      stall_nxt = ~i_out_stall;
                endcase
            end
            i_out_stall <= stall_nxt;
        end
    end

    // ------------------------------------------------------------------
    // monitor: field-by-field compare against the oldest prediction
    // ------------------------------------------------------------------
    t_out want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_expected.size() == 0) begin
                report_mismatch("with nothing pending, data", o_out_data, 0);
            end else begin
                want = result_expected.pop_front();
                if (o_out_data.motor_on !== want.motor_on)
                    report_mismatch("motor_on", o_out_data.motor_on, want.motor_on);
                if (o_out_data.in_window !== want.in_window)
                    report_mismatch("in_window", o_out_data.in_window, want.in_window);
                if (o_out_data.evaluated !== want.evaluated)
                    report_mismatch("evaluated", o_out_data.evaluated, want.evaluated);
                if (o_out_data.total_hours !== want.total_hours)
                    report_mismatch("total_hours", o_out_data.total_hours,
                                    want.total_hours);
                if (o_out_data.total_minutes !== want.total_minutes)
                    report_mismatch("total_minutes", o_out_data.total_minutes,
                                    want.total_minutes);
                if (o_out_data.hour_rolled !== want.hour_rolled)
                    report_mismatch("hour_rolled", o_out_data.hour_rolled,
                                    want.hour_rolled);
                evals_seen    += want.evaluated;
                running_evals += want.evaluated & want.motor_on;
                rolls_seen    += want.hour_rolled;
            end
            results_seen++;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_expected.size());
            $display("windowed_run_rest_cycle_timer: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    int walk_hour, walk_min;
    logic walk_en;

    task automatic add_tick(input int h, input int m, input int en);
        t_in item;
        item.now_hour   = HOUR_W'(h);
        item.now_minute = MINUTE_W'(m);
        item.enabled    = en[0];
        tick_pending.push_back(item);
    endtask

    // wait for every result, then let the output buffer settle
    task automatic wait_drained();
        while (tick_pending.size() != 0 || result_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        timer_set_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_timer(input int sh, input int sm, input int eh, input int em,
                             input int run, input int rest);
        write_reg(CFG_START_HOUR,   CFG_DATA_W'(sh));
        write_reg(CFG_START_MINUTE, CFG_DATA_W'(sm));
        write_reg(CFG_END_HOUR,     CFG_DATA_W'(eh));
        write_reg(CFG_END_MINUTE,   CFG_DATA_W'(em));
        write_reg(CFG_RUN_MINUTES,  CFG_DATA_W'(run));
        write_reg(CFG_REST_MINUTES, CFG_DATA_W'(rest));
    endtask

    // mostly a clock walking forward a minute at a time, with some noise
    task automatic queue_walk(input int h, input int m, input int count,
                              input int noise_pct);
        walk_hour = h;
        walk_min  = m;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                add_tick($urandom_range(0, 31), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    walk_min++;
                    if (walk_min == 60) begin
                        walk_min  = 0;
                        walk_hour = (walk_hour + 1) % 24;
                    end
                end
                if ($urandom_range(0, 199) == 0) begin
                    walk_hour = $urandom_range(0, 23);
                    walk_min  = $urandom_range(0, 59);
                end
                if ($urandom_range(0, 99) == 0) begin
                    walk_en = ~walk_en;
                end
                add_tick(walk_hour, walk_min, walk_en);
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        timer_reset();
        walk_en = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset window 08:00..20:00, every fourth tick acts
        add_tick(0, 0, 1);
        add_tick(31, 63, 1);
        add_tick(20, 0, 1);
        add_tick(8, 0, 1);       // first in-window tick: minute only recorded
        add_tick(20, 1, 1);
        add_tick(7, 59, 1);
        add_tick(8, 1, 1);
        add_tick(8, 1, 1);       // new minute: cycle advances, motor runs
        add_tick(8, 2, 0);       // power off clears the cycle, motor stops
        add_tick(8, 2, 0);
        add_tick(8, 2, 0);
        add_tick(8, 2, 0);       // acting while disabled
        add_tick(8, 3, 1);       // power back on
        add_tick(8, 3, 1);
        add_tick(8, 3, 1);
        add_tick(8, 4, 1);
        add_tick(8, 5, 1);
        add_tick(8, 5, 1);
        add_tick(8, 5, 1);
        add_tick(8, 5, 1);       // run span used up: rest phase
        add_tick(31, 63, 0);
        add_tick(0, 0, 1);
        add_tick(23, 59, 1);
        add_tick(20, 0, 1);      // window close is inclusive
        wait_drained();

        // window wrapping past midnight
        set_timer(22, 30, 5, 15, 3, 2);
        queue_walk(22, 25, 300, 10);

        // whole raw range in the window, run and rest both zero: motor on at every enabled acting tick
        set_timer(0, 0, 63, 63, 0, 0);
        queue_walk(11, 0, 200, 30);

        // long run span so the minute total rolls over the hour
        set_timer(0, 0, 23, 59, 59, 1);
        queue_walk(6, 0, 450, 5);

        // register extremes: start at the top of the raw range, stop at zero
        set_timer(63, 63, 0, 0, 63, 63);
        queue_walk(23, 50, 150, 50);

        // single-minute window, shortest nonzero run with a 59-minute rest
        set_timer(12, 34, 12, 34, 1, 59);
        queue_walk(12, 30, 150, 10);

        // writes past the register list change nothing
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '0);
        set_timer(7, 50, 9, 10, 5, 3);
        queue_walk(7, 40, 330, 10);

        if (result_expected.size() != 0) begin
            report_mismatch("left over, count", result_expected.size(), 0);
        end
        $display("checked %0d results over seven timer setups, %0d acting ticks",
                 results_seen, evals_seen);
        $display("motor on at %0d acting ticks, %0d hour rollovers, %0d receiver hold-offs",
                 running_evals, rolls_seen, holds_done);
        if (mismatch_count == 0) begin
            $display("windowed_run_rest_cycle_timer: match");
        end else begin
            $display("windowed_run_rest_cycle_timer: mismatch");
        end
        $finish;
    end

endmodule
